// ----- hw/rtl/twbrt_pkg.sv -----
`timescale 1ns / 1ps

package twbrt_pkg;

  localparam logic [1:0] REQ_UPDATE  = 2'd0;
  localparam logic [1:0] REQ_LOOKUP  = 2'd1;
  localparam logic [1:0] REQ_REFRESH = 2'd2;
  localparam logic [1:0] REQ_CLEAR   = 2'd3;

  localparam logic [6:0] NO_MOVE         = 7'd64;
  localparam logic [7:0] AGE_LIMIT_RESET = 8'd6;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [9:0]         bucket;
    logic [63:0]        player_bits;
    logic [63:0]        opponent_bits;
    logic [7:0]         date;
    logic [5:0]         new_depth;
    logic [2:0]         new_selectivity;
    logic [31:0]        new_cost;
    logic signed [7:0]  new_alpha;
    logic signed [7:0]  new_beta;
    logic [6:0]         new_best_move;
    logic [6:0]         new_alt_move;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic [5:0]         out_depth;
    logic [2:0]         out_selectivity;
    logic [31:0]        out_cost;
    logic signed [7:0]  out_alpha;
    logic signed [7:0]  out_beta;
    logic [6:0]         out_best_move;
    logic [6:0]         out_alt_move;
  } rsp_t;

  typedef struct packed {
    logic [5:0]         depth;
    logic [2:0]         selectivity;
    logic [31:0]        cost;
    logic signed [7:0]  alpha;
    logic signed [7:0]  beta;
    logic [6:0]         best_move;
    logic [6:0]         alt_move;
  } entry_t;

  typedef struct packed {
    logic [63:0] pkey;
    logic [63:0] okey;
    entry_t      entry;
    logic [7:0]  date;
  } slot_t;

  // one memory row: slot one and slot two of a bucket
  typedef struct packed {
    slot_t s1;
    slot_t s2;
  } bucket_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_e;

endpackage

// ----- hw/rtl/twbrt_if.sv -----
`timescale 1ns / 1ps

interface twbrt_req_if;
  logic              valid;
  logic              ready;
  twbrt_pkg::req_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface twbrt_rsp_if;
  logic              valid;
  logic              ready;
  twbrt_pkg::rsp_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface twbrt_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/twbrt_mem.sv -----
`timescale 1ns / 1ps

module twbrt_mem #(
  parameter int AW = 10
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic                we_i,
  input  logic [AW-1:0]       addr_i,
  input  twbrt_pkg::bucket_t  wdata_i,
  output twbrt_pkg::bucket_t  rdata_o
);

  twbrt_pkg::bucket_t mem_q [2**AW];
  twbrt_pkg::bucket_t rdata_q;

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/twbrt_merge.sv -----
`timescale 1ns / 1ps

module twbrt_merge (
  input  twbrt_pkg::req_t     req_i,
  input  twbrt_pkg::bucket_t  old_i,
  input  logic [7:0]          age_limit_i,
  output twbrt_pkg::bucket_t  new_o,
  output twbrt_pkg::rsp_t     rsp_o
);

  logic               m1, m2, hit;
  logic signed [8:0]  diff1, diff2, lim;
  logic               old1, old2;
  twbrt_pkg::entry_t  offered;
  twbrt_pkg::slot_t   new_slot;

  function automatic twbrt_pkg::entry_t merge_entry(twbrt_pkg::entry_t cur,
                                                    twbrt_pkg::entry_t nw);
    twbrt_pkg::entry_t res;
    res = cur;
    if (nw.depth > cur.depth ||
        (nw.depth == cur.depth && nw.selectivity < cur.selectivity)) begin
      res = nw;
    end else if (nw.depth == cur.depth && nw.selectivity == cur.selectivity) begin
      if (nw.cost > cur.cost) res.cost = nw.cost;
      if (nw.alpha > cur.alpha) res.alpha = nw.alpha;
      if (nw.beta < cur.beta) res.beta = nw.beta;
      res.best_move = nw.best_move;
      res.alt_move  = nw.alt_move;
    end
    return res;
  endfunction

  assign m1  = (old_i.s1.pkey == req_i.player_bits) && (old_i.s1.okey == req_i.opponent_bits);
  assign m2  = (old_i.s2.pkey == req_i.player_bits) && (old_i.s2.okey == req_i.opponent_bits);
  assign hit = (req_i.req_type != twbrt_pkg::REQ_CLEAR) && (m1 || m2);

  // date difference is signed, -255..255
  assign diff1 = $signed({1'b0, req_i.date}) - $signed({1'b0, old_i.s1.date});
  assign diff2 = $signed({1'b0, req_i.date}) - $signed({1'b0, old_i.s2.date});
  assign lim   = $signed({1'b0, age_limit_i});
  assign old1  = diff1 >= lim;
  assign old2  = diff2 >= lim;

  assign offered = '{depth:       req_i.new_depth,
                     selectivity: req_i.new_selectivity,
                     cost:        req_i.new_cost,
                     alpha:       req_i.new_alpha,
                     beta:        req_i.new_beta,
                     best_move:   req_i.new_best_move,
                     alt_move:    req_i.new_alt_move};

  assign new_slot = '{pkey:  req_i.player_bits,
                      okey:  req_i.opponent_bits,
                      entry: offered,
                      date:  req_i.date};

  always_comb begin
    new_o = old_i;
    rsp_o = '0;
    rsp_o.hit           = hit;
    rsp_o.out_best_move = twbrt_pkg::NO_MOVE;
    rsp_o.out_alt_move  = twbrt_pkg::NO_MOVE;
    unique case (req_i.req_type)
      twbrt_pkg::REQ_UPDATE: begin
        priority if (m1) begin
          new_o.s1.entry = merge_entry(old_i.s1.entry, offered);
          new_o.s1.date  = req_i.date;
        end else if (m2) begin
          new_o.s2.entry = merge_entry(old_i.s2.entry, offered);
          new_o.s2.date  = req_i.date;
        end else if (req_i.new_cost > old_i.s1.entry.cost) begin
          new_o.s2 = old_i.s1;
          new_o.s1 = new_slot;
        end else if (req_i.new_cost > old_i.s2.entry.cost) begin
          new_o.s2 = new_slot;
        end else if (old1 && old2) begin
          new_o.s2 = old_i.s1;
          new_o.s1 = new_slot;
        end else if (old2) begin
          new_o.s2 = new_slot;
        end else if (old1) begin
          new_o.s1 = old_i.s2;
          new_o.s2 = new_slot;
        end else begin
          new_o = old_i;
        end
      end
      twbrt_pkg::REQ_LOOKUP: begin
        if (hit) begin
          rsp_o.out_depth       = m1 ? old_i.s1.entry.depth       : old_i.s2.entry.depth;
          rsp_o.out_selectivity = m1 ? old_i.s1.entry.selectivity : old_i.s2.entry.selectivity;
          rsp_o.out_cost        = m1 ? old_i.s1.entry.cost        : old_i.s2.entry.cost;
          rsp_o.out_alpha       = m1 ? old_i.s1.entry.alpha       : old_i.s2.entry.alpha;
          rsp_o.out_beta        = m1 ? old_i.s1.entry.beta        : old_i.s2.entry.beta;
          rsp_o.out_best_move   = m1 ? old_i.s1.entry.best_move   : old_i.s2.entry.best_move;
          rsp_o.out_alt_move    = m1 ? old_i.s1.entry.alt_move    : old_i.s2.entry.alt_move;
        end
      end
      twbrt_pkg::REQ_REFRESH: begin
        if (m1) begin
          new_o.s1.date = req_i.date;
        end else if (m2) begin
          new_o.s2.date = req_i.date;
        end
      end
      twbrt_pkg::REQ_CLEAR: begin
        // keys and dates stay
        new_o.s1.entry = '0;
        new_o.s2.entry = '0;
      end
    endcase
  end

endmodule

// ----- hw/rtl/two_way_bucket_replacement_table.sv -----
`timescale 1ns / 1ps

// Two-way bucket replacement table. Each of the 2^BUCKET_BITS buckets holds two
// ordered slots (key, entry, date) in one row of a single-port memory. A request
// (update, lookup, refresh, clear) is accepted when the block is idle and its bucket
// row is read at that same edge; then the merged row is written back and the result
// item is loaded into the output register; the read and the write-back share the
// one memory port, so no new request is accepted until the write-back is done;
// if the previous result is still held the write-back waits for it to be taken.
// After reset a clearing pass writes zero to every row, one row a cycle; during
// the pass no request is accepted; age_limit writes are taken at any time.
module two_way_bucket_replacement_table #(
  parameter int BUCKET_BITS = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  twbrt_cfg_if.sink        cfg_i,
  twbrt_req_if.sink        req_i,
  twbrt_rsp_if.source      rsp_o
);

  twbrt_pkg::state_e   state_q, state_d;
  logic [BUCKET_BITS-1:0] clr_addr_q, clr_addr_d;
  logic [7:0]          age_q;
  twbrt_pkg::req_t     req_q, req_d;
  twbrt_pkg::rsp_t     rsp_q, rsp_d;
  logic                rsp_valid_q, rsp_valid_d;

  logic                mem_en, mem_we;
  logic [BUCKET_BITS-1:0] mem_addr;
  twbrt_pkg::bucket_t  mem_wdata, mem_rdata, merged;
  twbrt_pkg::rsp_t     rsp_new;

  twbrt_mem #(.AW(BUCKET_BITS)) u_mem (
    .clk_i   (clk_i),
    .en_i    (mem_en),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  twbrt_merge u_merge (
    .req_i       (req_q),
    .old_i       (mem_rdata),
    .age_limit_i (age_q),
    .new_o       (merged),
    .rsp_o       (rsp_new)
  );

  assign cfg_i.ready = 1'b1;
  assign req_i.ready = (state_q == twbrt_pkg::ST_IDLE);
  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      age_q <= twbrt_pkg::AGE_LIMIT_RESET;
    end else if (cfg_i.valid) begin
      age_q <= cfg_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= twbrt_pkg::ST_CLEAR;
      clr_addr_q  <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    rsp_q <= rsp_d;
  end

  always_comb begin
    state_d     = state_q;
    clr_addr_d  = clr_addr_q;
    req_d       = req_q;
    rsp_d       = rsp_q;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    mem_en      = 1'b0;
    mem_we      = 1'b0;
    mem_addr    = BUCKET_BITS'(req_q.bucket);
    mem_wdata   = merged;
    unique case (state_q)
      twbrt_pkg::ST_CLEAR: begin
        mem_en     = 1'b1;
        mem_we     = 1'b1;
        mem_addr   = clr_addr_q;
        mem_wdata  = '0;
        clr_addr_d = clr_addr_q + BUCKET_BITS'(1);
        if (&clr_addr_q) begin
          state_d = twbrt_pkg::ST_IDLE;
        end
      end
      twbrt_pkg::ST_IDLE: begin
        if (req_i.valid) begin
          mem_en   = 1'b1;
          mem_addr = BUCKET_BITS'(req_i.data.bucket);
          req_d    = req_i.data;
          state_d  = twbrt_pkg::ST_EXEC;
        end
      end
      twbrt_pkg::ST_EXEC: begin
        // write back and emit once the output register is free
        if (!rsp_valid_q || rsp_o.ready) begin
          mem_en      = 1'b1;
          mem_we      = 1'b1;
          rsp_d       = rsp_new;
          rsp_valid_d = 1'b1;
          state_d     = twbrt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = twbrt_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_accept_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> state_q == twbrt_pkg::ST_EXEC)
    else $error("accepted item did not start execution");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == twbrt_pkg::ST_IDLE |-> !mem_we)
    else $error("memory written while idle");

  a_rsp_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> $past(state_q) == twbrt_pkg::ST_EXEC)
    else $error("result item without execution");

  a_no_rsp_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == twbrt_pkg::ST_CLEAR |-> !rsp_valid_q)
    else $error("result item during clearing pass");
`endif

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import twbrt_pkg::*;

  localparam int CYCLE_LIMIT         = 600000;
  localparam int SLOT_COUNT          = 2048;
  localparam int MAX_SEND_GAP        = 30;
  localparam int BACKPRESSURE_CYCLES = 300;
  localparam int MAX_REPORTS         = 100;

  logic clk;
  logic rst_n;

  twbrt_cfg_if cfg_if ();
  twbrt_req_if req_if ();
  twbrt_rsp_if rsp_if ();

  two_way_bucket_replacement_table u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_if),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // shadow copy of the bucket store, slot s of bucket b at 2*b + s
  slot_t       shadow_slots [SLOT_COUNT];
  logic [7:0]  shadow_age_limit;
  rsp_t        expected_rsp_q [$];

  int          mismatch_count;
  int          result_count;
  int          cycle_count;
  int          tx_idle_pct;
  int          rx_stall_pct;
  int          rx_hold_cycles;

  logic [63:0] pkey_pool [8];
  logic [63:0] okey_pool [8];
  logic [9:0]  hot_buckets [6];
  logic [7:0]  date_now;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL two_way_bucket_replacement_table");
      $finish;
    end
  end

  // result side ready, with a counted hold-off for the backpressure test
  always @(negedge clk) begin
    if (rx_hold_cycles > 0) begin
      rsp_if.ready = 1'b0;
      rx_hold_cycles--;
    end else begin
      rsp_if.ready = ($urandom_range(99) >= rx_stall_pct);
    end
  end

  function automatic entry_t entry_from_request(input req_t r);
    entry_t e;
    e.depth       = r.new_depth;
    e.selectivity = r.new_selectivity;
    e.cost        = r.new_cost;
    e.alpha       = r.new_alpha;
    e.beta        = r.new_beta;
    e.best_move   = r.new_best_move;
    e.alt_move    = r.new_alt_move;
    return e;
  endfunction

  function automatic slot_t fresh_slot(input req_t r);
    slot_t s;
    s.pkey  = r.player_bits;
    s.okey  = r.opponent_bits;
    s.entry = entry_from_request(r);
    s.date  = r.date;
    return s;
  endfunction

  function automatic entry_t merge_entry(input entry_t e, input req_t r);
    if (r.new_depth > e.depth ||
        (r.new_depth == e.depth && r.new_selectivity < e.selectivity)) begin
      return entry_from_request(r);
    end
    if (r.new_depth == e.depth && r.new_selectivity == e.selectivity) begin
      if (r.new_cost > e.cost) e.cost = r.new_cost;
      if ($signed(r.new_alpha) > $signed(e.alpha)) e.alpha = r.new_alpha;
      if ($signed(r.new_beta) < $signed(e.beta)) e.beta = r.new_beta;
      e.best_move = r.new_best_move;
      e.alt_move  = r.new_alt_move;
    end
    return e;
  endfunction

  // applies one request to the shadow store and returns the result it gives
  function automatic rsp_t predict_response(input req_t r);
    rsp_t        rsp;
    entry_t      e;
    slot_t       a;
    slot_t       b;
    int unsigned i1;
    int unsigned i2;
    logic        m1;
    logic        m2;
    logic        old1;
    logic        old2;
    i1 = 32'({r.bucket, 1'b0});
    i2 = i1 + 1;
    a  = shadow_slots[i1];
    b  = shadow_slots[i2];
    m1 = (a.pkey == r.player_bits) && (a.okey == r.opponent_bits);
    m2 = (b.pkey == r.player_bits) && (b.okey == r.opponent_bits);
    rsp = '0;
    rsp.out_best_move = NO_MOVE;
    rsp.out_alt_move  = NO_MOVE;
    rsp.hit = (r.req_type != REQ_CLEAR) && (m1 || m2);
    case (r.req_type)
      REQ_UPDATE: begin
        if (m1) begin
          a.entry = merge_entry(a.entry, r);
          a.date  = r.date;
        end else if (m2) begin
          b.entry = merge_entry(b.entry, r);
          b.date  = r.date;
        end else if (r.new_cost > a.entry.cost) begin
          b = a;
          a = fresh_slot(r);
        end else if (r.new_cost > b.entry.cost) begin
          b = fresh_slot(r);
        end else begin
          // signed date difference, so a date that wrapped back is young
          old1 = (int'(r.date) - int'(a.date)) >= int'(shadow_age_limit);
          old2 = (int'(r.date) - int'(b.date)) >= int'(shadow_age_limit);
          if (old1 && old2) begin
            b = a;
            a = fresh_slot(r);
          end else if (!old1 && old2) begin
            b = fresh_slot(r);
          end else if (old1 && !old2) begin
            a = b;
            b = fresh_slot(r);
          end
        end
      end
      REQ_LOOKUP: begin
        if (rsp.hit) begin
          e = m1 ? a.entry : b.entry;
          rsp.out_depth       = e.depth;
          rsp.out_selectivity = e.selectivity;
          rsp.out_cost        = e.cost;
          rsp.out_alpha       = e.alpha;
          rsp.out_beta        = e.beta;
          rsp.out_best_move   = e.best_move;
          rsp.out_alt_move    = e.alt_move;
        end
      end
      REQ_REFRESH: begin
        if (m1) a.date = r.date;
        else if (m2) b.date = r.date;
      end
      default: begin
        a.entry = '0;
        b.entry = '0;
      end
    endcase
    shadow_slots[i1] = a;
    shadow_slots[i2] = b;
    return rsp;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("%0t ns: result %0d, %s: got 0x%0h, expected 0x%0h",
               $realtime, result_count, what, got, want);
    end
  endtask

  task automatic check_result(input rsp_t got, input rsp_t want);
    if (got.hit !== want.hit) report_mismatch("hit", 64'(got.hit), 64'(want.hit));
    if (got.out_depth !== want.out_depth)
      report_mismatch("out_depth", 64'(got.out_depth), 64'(want.out_depth));
    if (got.out_selectivity !== want.out_selectivity)
      report_mismatch("out_selectivity", 64'(got.out_selectivity),
                      64'(want.out_selectivity));
    if (got.out_cost !== want.out_cost)
      report_mismatch("out_cost", 64'(got.out_cost), 64'(want.out_cost));
    if (got.out_alpha !== want.out_alpha)
      report_mismatch("out_alpha", 64'(got.out_alpha), 64'(want.out_alpha));
    if (got.out_beta !== want.out_beta)
      report_mismatch("out_beta", 64'(got.out_beta), 64'(want.out_beta));
    if (got.out_best_move !== want.out_best_move)
      report_mismatch("out_best_move", 64'(got.out_best_move), 64'(want.out_best_move));
    if (got.out_alt_move !== want.out_alt_move)
      report_mismatch("out_alt_move", 64'(got.out_alt_move), 64'(want.out_alt_move));
  endtask

  always @(posedge clk) begin
    if (rst_n && req_if.valid && req_if.ready) begin
      expected_rsp_q.push_back(predict_response(req_if.data));
    end
  end

  always @(posedge clk) begin
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      if (expected_rsp_q.size() == 0) begin
        report_mismatch("result item with nothing expected", 64'(rsp_if.data), 64'd0);
      end else begin
        check_result(rsp_if.data, expected_rsp_q.pop_front());
      end
      result_count++;
    end
  end

  task automatic send_item(input req_t item);
    int gap;
    gap = 0;
    while (gap < MAX_SEND_GAP && $urandom_range(99) < tx_idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      req_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.data  = item;
    req_if.valid = 1'b1;
    do @(posedge clk); while (!req_if.ready);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    req_if.valid = 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_age_limit(input logic [7:0] value);
    @(negedge clk);
    cfg_if.data  = value;
    cfg_if.valid = 1'b1;
    do @(posedge clk); while (!cfg_if.ready);
    shadow_age_limit = value;
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  function automatic req_t make_req(
    input logic [1:0]        kind,
    input logic [9:0]        bkt,
    input logic [63:0]       pk,
    input logic [63:0]       ok,
    input logic [7:0]        dt,
    input logic [5:0]        dep,
    input logic [2:0]        sel,
    input logic [31:0]       cost,
    input logic signed [7:0] lo,
    input logic signed [7:0] hi,
    input logic [6:0]        mv,
    input logic [6:0]        alt
  );
    req_t r;
    r.req_type        = kind;
    r.bucket          = bkt;
    r.player_bits     = pk;
    r.opponent_bits   = ok;
    r.date            = dt;
    r.new_depth       = dep;
    r.new_selectivity = sel;
    r.new_cost        = cost;
    r.new_alpha       = lo;
    r.new_beta        = hi;
    r.new_best_move   = mv;
    r.new_alt_move    = alt;
    return r;
  endfunction

  // mostly a few hot buckets and a small key set so that hits, merges and
  // replacements keep happening; the rest is fully random
  function automatic req_t random_request();
    req_t r;
    int   pick;
    int   ki;
    pick = $urandom_range(99);
    r.req_type = (pick < 45) ? REQ_UPDATE  :
                 (pick < 80) ? REQ_LOOKUP  :
                 (pick < 92) ? REQ_REFRESH : REQ_CLEAR;
    r.bucket = ($urandom_range(99) < 75) ? hot_buckets[$urandom_range(5)] : 10'($urandom);
    ki   = $urandom_range(7);
    pick = $urandom_range(99);
    if (pick < 80) begin
      r.player_bits   = pkey_pool[ki];
      r.opponent_bits = okey_pool[ki];
    end else if (pick < 90) begin
      r.player_bits   = pkey_pool[ki];
      r.opponent_bits = okey_pool[$urandom_range(7)];
    end else begin
      r.player_bits   = {$urandom, $urandom};
      r.opponent_bits = {$urandom, $urandom};
    end
    if ($urandom_range(9) == 0) date_now = date_now + 8'($urandom_range(8, 1));
    r.date = ($urandom_range(99) < 85) ? date_now - 8'($urandom_range(3)) : 8'($urandom);
    r.new_depth = ($urandom_range(99) < 60) ? 6'($urandom_range(3)) : 6'($urandom);
    r.new_selectivity = ($urandom_range(99) < 60) ? 3'($urandom_range(1)) : 3'($urandom);
    case ($urandom_range(3))
      0:       r.new_cost = $urandom_range(15);
      1:       r.new_cost = $urandom;
      2:       r.new_cost = ($urandom_range(1) == 1) ? 32'hffff_ffff : 32'h0;
      default: r.new_cost = $urandom_range(1000);
    endcase
    r.new_alpha = ($urandom_range(99) < 80) ? 8'(int'($urandom_range(128)) - 64)
                                             : 8'($urandom);
    r.new_beta  = ($urandom_range(99) < 80) ? 8'(int'($urandom_range(128)) - 64)
                                             : 8'($urandom);
    r.new_best_move = ($urandom_range(99) < 85) ? 7'($urandom_range(64)) : 7'($urandom);
    r.new_alt_move  = ($urandom_range(99) < 85) ? 7'($urandom_range(64)) : 7'($urandom);
    return r;
  endfunction

  task automatic test_directed_cases();
    logic [63:0] ka;
    logic [63:0] kb;
    logic [63:0] kc;
    logic [63:0] kd;
    logic [63:0] ke;
    logic [63:0] kf;
    ka = 64'h0123_4567_89ab_cdef;
    kb = 64'h0000_0000_0000_0001;
    kc = 64'h8000_0000_0000_0000;
    kd = 64'h5555_aaaa_5555_aaaa;
    ke = 64'hdead_0000_beef_0000;
    kf = 64'h0f0f_0f0f_f0f0_f0f0;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    // zero key matches both empty slots, slot one wins
    send_item(make_req(REQ_LOOKUP, 10'd0, '0, '0, 8'd0, 6'd0, 3'd0, 32'd0, 8'sd0, 8'sd0,
                       7'd0, 7'd0));
    send_item(make_req(REQ_UPDATE, 10'd0, '0, '0, 8'd3, 6'd5, 3'd2, 32'd7, 8'sd10, 8'sd20,
                       7'd12, 7'd13));
    send_item(make_req(REQ_LOOKUP, 10'd0, '0, '0, 8'd0, 6'd0, 3'd0, 32'd0, 8'sd0, 8'sd0,
                       7'd0, 7'd0));
    // fill bucket 5: costly entry into slot one, cheaper one into slot two
    send_item(make_req(REQ_UPDATE, 10'd5, ka, ~ka, 8'd10, 6'd10, 3'd3, 32'd100, -8'sd5,
                       8'sd30, 7'd19, 7'd20));
    send_item(make_req(REQ_UPDATE, 10'd5, kb, ~kb, 8'd10, 6'd4, 3'd1, 32'd50, 8'sd1, 8'sd2,
                       7'd3, 7'd4));
    send_item(make_req(REQ_LOOKUP, 10'd5, kb, ~kb, 8'd0, 6'd0, 3'd0, 32'd0, 8'sd0, 8'sd0,
                       7'd0, 7'd0));
    // equal depth and selectivity merge, then better selectivity, shallower, deeper
    send_item(make_req(REQ_UPDATE, 10'd5, ka, ~ka, 8'd11, 6'd10, 3'd3, 32'd80, 8'sd7,
                       8'sd12, 7'd1, 7'd2));
    send_item(make_req(REQ_UPDATE, 10'd5, ka, ~ka, 8'd11, 6'd10, 3'd2, 32'd5, 8'sd3,
                       8'sd9, 7'd5, 7'd6));
    send_item(make_req(REQ_UPDATE, 10'd5, ka, ~ka, 8'd12, 6'd9, 3'd0, 32'd999, 8'sd60,
                       -8'sd60, 7'd7, 7'd8));
    send_item(make_req(REQ_UPDATE, 10'd5, ka, ~ka, 8'd12, 6'd11, 3'd4, 32'd200, -8'sd64,
                       8'sd64, 7'd64, 7'd64));
    send_item(make_req(REQ_LOOKUP, 10'd5, ka, ~ka, 8'd0, 6'd0, 3'd0, 32'd0, 8'sd0, 8'sd0,
                       7'd0, 7'd0));
    // cheap miss with both slots young leaves the bucket alone
    send_item(make_req(REQ_UPDATE, 10'd5, kc, ~kc, 8'd12, 6'd1, 3'd1, 32'd1, 8'sd0, 8'sd0,
                       7'd9, 7'd9));
    send_item(make_req(REQ_LOOKUP, 10'd5, kc, ~kc, 8'd0, 6'd0, 3'd0, 32'd0, 8'sd0, 8'sd0,
                       7'd0, 7'd0));
    send_item(make_req(REQ_REFRESH, 10'd5, ka, ~ka, 8'd30, 6'd0, 3'd0, 32'd0, 8'sd0, 8'sd0,
                       7'd0, 7'd0));
    // only slot two old
    send_item(make_req(REQ_UPDATE, 10'd5, kc, ~kc, 8'd16, 6'd1, 3'd1, 32'd1, 8'sd0, 8'sd0,
                       7'd9, 7'd9));
    send_item(make_req(REQ_REFRESH, 10'd5, kc, ~kc, 8'd40, 6'd0, 3'd0, 32'd0, 8'sd0, 8'sd0,
                       7'd0, 7'd0));
    // only slot one old: slot two moves up
    send_item(make_req(REQ_UPDATE, 10'd5, kd, ~kd, 8'd36, 6'd2, 3'd0, 32'd1, 8'sd4, 8'sd5,
                       7'd10, 7'd11));
    // both old: shift slot one down
    send_item(make_req(REQ_UPDATE, 10'd5, ke, ~ke, 8'd250, 6'd3, 3'd5, 32'd0, 8'sd6,
                       8'sd7, 7'd14, 7'd15));
    // date wrapped back gives a negative difference, nothing is old
    send_item(make_req(REQ_UPDATE, 10'd5, kf, ~kf, 8'd0, 6'd3, 3'd0, 32'd0, 8'sd0, 8'sd0,
                       7'd0, 7'd0));
    send_item(make_req(REQ_REFRESH, 10'd5, kf, ~kf, 8'd99, 6'd0, 3'd0, 32'd0, 8'sd0, 8'sd0,
                       7'd0, 7'd0));
    // clear keeps keys, so a lookup still hits with a zero entry
    send_item(make_req(REQ_CLEAR, 10'd5, ke, ~ke, 8'd0, 6'd0, 3'd0, 32'd0, 8'sd0, 8'sd0,
                       7'd0, 7'd0));
    send_item(make_req(REQ_LOOKUP, 10'd5, ke, ~ke, 8'd0, 6'd0, 3'd0, 32'd0, 8'sd0, 8'sd0,
                       7'd0, 7'd0));
    // field extremes on the last bucket
    send_item(make_req(REQ_UPDATE, 10'h3ff, '1, '1, 8'hff, 6'd63, 3'd7, 32'hffff_ffff,
                       8'sd64, -8'sd64, 7'd64, 7'd64));
    send_item(make_req(REQ_UPDATE, 10'h3ff, '1, '1, 8'hff, 6'd63, 3'd7, 32'hffff_ffff,
                       8'sh80, 8'sh7f, 7'h7f, 7'h7f));
    send_item(make_req(REQ_LOOKUP, 10'h3ff, '1, '1, 8'd0, 6'd0, 3'd0, 32'd0, 8'sd0, 8'sd0,
                       7'd0, 7'd0));
  endtask

  task automatic test_random_traffic(input int count, input logic [7:0] age,
                                     input int tx_pct, input int rx_pct);
    wait_drained();
    write_age_limit(age);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    repeat (count) send_item(random_request());
  endtask

  task automatic test_output_backpressure();
    wait_drained();
    write_age_limit(AGE_LIMIT_RESET);
    tx_idle_pct    = 0;
    rx_stall_pct   = 0;
    rx_hold_cycles = BACKPRESSURE_CYCLES;
    repeat (40) send_item(random_request());
    // hold the input back until every outstanding result is out
    wait_drained();
    rx_stall_pct = 50;
    repeat (30) send_item(random_request());
  endtask

  initial begin
    rst_n          = 1'b0;
    cfg_if.valid   = 1'b0;
    cfg_if.data    = '0;
    req_if.valid   = 1'b0;
    req_if.data    = '0;
    rsp_if.ready   = 1'b0;
    tx_idle_pct    = 0;
    rx_stall_pct   = 0;
    rx_hold_cycles = 0;
    mismatch_count = 0;
    result_count   = 0;
    cycle_count    = 0;
    date_now       = 8'd0;
    shadow_age_limit = AGE_LIMIT_RESET;
    foreach (shadow_slots[i]) shadow_slots[i] = '0;
    pkey_pool[0] = '0;
    okey_pool[0] = '0;
    pkey_pool[1] = '1;
    okey_pool[1] = '1;
    for (int k = 2; k < 8; k++) begin
      pkey_pool[k] = {$urandom, $urandom};
      okey_pool[k] = {$urandom, $urandom};
    end
    hot_buckets[0] = 10'd0;
    hot_buckets[1] = 10'h3ff;
    hot_buckets[2] = 10'd5;
    for (int k = 3; k < 6; k++) hot_buckets[k] = 10'($urandom);
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    test_directed_cases();
    test_random_traffic(480, 8'd0, 0, 0);
    test_random_traffic(470, 8'd255, 86, 0);
    test_random_traffic(470, 8'd1, 0, 86);
    test_random_traffic(400, 8'($urandom_range(20, 2)), 31, 31);
    test_output_backpressure();

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS two_way_bucket_replacement_table");
    end else begin
      $display("FAIL two_way_bucket_replacement_table");
    end
    $finish;
  end

endmodule
